// ===== hdl/value_rank_transform_unit_defines.svh =====
`ifndef VALUE_RANK_TRANSFORM_UNIT_DEFINES_SVH
`define VALUE_RANK_TRANSFORM_UNIT_DEFINES_SVH

// clocked assertion, quiet during reset
`define VRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hdl/vrt_pkg.sv =====
package vrt_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 64;

  typedef struct packed {
    logic [VAL_W-1:0] value_bits;
    logic             last_value;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] rank;
    logic             last_rank;
    logic             overflowed;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] tgt;
  } tok_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_OUT
  } state_t;

  function automatic logic is_nan(input logic [VAL_W-1:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  // unsigned compare order; both zeros map to the same key
  function automatic logic [VAL_W-1:0] to_key(input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] k;
    if (b[62:0] == 63'd0) begin
      k = {1'b1, 63'd0};
    end else if (b[63]) begin
      k = ~b;
    end else begin
      k = {1'b1, b[62:0]};
    end
    return k;
  endfunction

endpackage

// ===== hdl/vrt_cell.sv =====
module vrt_cell
  import vrt_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  input  logic             shift,
  input  logic [CNT_W-1:0] rank_in,
  output logic [CNT_W-1:0] rank_out
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

  logic [VAL_W-1:0] key;
  logic [CNT_W-1:0] rank;
  logic             here;
  logic             tok_less;

  assign here     = tok_in.valid && (tok_in.tgt == IDX);
  assign tok_less = tok_in.key < key;
  assign rank_out = rank;

  always_ff @(posedge clk) begin
    tok_out.key <= tok_in.key;
    tok_out.tgt <= tok_in.tgt;
    tok_out.cnt <= (tok_in.valid && !tok_less) ? tok_in.cnt + CNT_W'(1) : tok_in.cnt;
    if (here) begin
      key  <= tok_in.key;
      rank <= tok_in.cnt + CNT_W'(1);
    end else if (shift) begin
      rank <= rank_in;
    end else if (tok_in.valid && tok_less) begin
      rank <= rank + CNT_W'(1);
    end
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid && !here;
    end
  end

endmodule

// ===== hdl/value_rank_transform_unit.sv =====
// Values ripple along a chain of compare cells, one cell per cycle.
// Input: one transaction per cycle while loading; after the last one the
// chain drains until no token is in flight, then the ranks of the stored
// values (at most MAX_ITEMS) leave one per cycle while out_ready is high,
// in arrival order. No input is taken while draining or emitting.
// Reset (rst, synchronous) empties the set and clears the overflow flag.
module value_rank_transform_unit
  import vrt_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] pos;
  logic             ovf;
  tok_t             tok [MAX_ITEMS+1];
  logic [CNT_W-1:0] rnk [MAX_ITEMS+1];
  logic [MAX_ITEMS:0] busy;
  logic             in_acc, out_acc, shift, final_out, room, nan_in;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign shift     = out_acc;
  assign final_out = ({1'b0, pos} == count - CNT_W'(1));
  assign room      = count < CNT_W'(MAX_ITEMS);
  assign nan_in    = is_nan(in_data.value_bits);
  assign rnk[MAX_ITEMS] = '0;

  for (genvar i = 0; i <= MAX_ITEMS; i++) begin : g_busy
    assign busy[i] = tok[i].valid;
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    vrt_cell #(.CELL_IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .shift    (shift),
      .rank_in  (rnk[i+1]),
      .rank_out (rnk[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (in_acc && in_data.last_value) state_next = ST_DRAIN;
      ST_DRAIN: if (busy == '0) state_next = (count == '0) ? ST_LOAD : ST_OUT;
      ST_OUT:   if (out_acc && final_out) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready            = (state == ST_LOAD);
    out_valid           = (state == ST_OUT);
    out_data.position   = pos;
    out_data.rank       = rnk[0];
    out_data.last_rank  = final_out;
    out_data.overflowed = ovf;
  end

  always_ff @(posedge clk) begin
    tok[0].key <= to_key(in_data.value_bits);
    tok[0].cnt <= '0;
    tok[0].tgt <= count;
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      pos       <= '0;
      ovf       <= 1'b0;
      tok[0].valid <= 1'b0;
    end else begin
      state        <= state_next;
      tok[0].valid <= in_acc && !nan_in && room;
      if (in_acc && !nan_in) begin
        if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (out_acc) begin
        pos <= pos + POS_W'(1);
      end
      if (state != ST_LOAD && state_next == ST_LOAD) begin
        count <= '0;
        pos   <= '0;
        ovf   <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/vrt_checker.sv =====
`include "value_rank_transform_unit_defines.svh"

module vrt_checker
  import vrt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `VRT_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while emitting")
  `VRT_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data), "input not held")
  `VRT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result not held")
  `VRT_ASSERT(a_end_set, out_valid && out_ready && out_data.last_rank |=> !out_valid, "results after last")
  `VRT_ASSERT(a_continue, out_valid && out_ready && !out_data.last_rank |=> out_valid, "set cut short")

endmodule

bind value_rank_transform_unit vrt_checker u_vrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
